[rtl/assert_macros.svh]
// assertion macros shared by the affine point transform rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// cond must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: never");
// ante at one edge requires cons at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next");
// ante requires cons at the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implies");
`else
`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/apt_pkg.sv]
// types and constants of the affine point transform unit
// no dependencies; used by every module of the block
`default_nettype none
package apt_pkg;

    localparam int unsigned FRAC_BITS_DEFAULT = 16;
    localparam int unsigned QUEUE_DEPTH       = 4;
    localparam int unsigned ROWS              = 3;
    localparam int unsigned COLS              = 4;
    localparam int unsigned ELEMS             = ROWS * COLS;
    localparam int unsigned WORD_W            = 32;
    localparam int unsigned PROD_W            = 2 * WORD_W;
    // three full products plus the scaled translation, with headroom
    localparam int unsigned SUM_W             = PROD_W + 2;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_XFORM = 1'b1
    } cmd_t;

    localparam logic [1:0] ROW_NONE = 2'd3;

    typedef struct packed {
        logic               command;
        logic [1:0]         row_index;
        logic [1:0]         column_index;
        logic signed [31:0] element_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } out_beat_t;

    // one classified item as it travels from front to back
    typedef struct packed {
        cmd_t               op;
        logic [3:0]         addr;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } entry_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

[rtl/apt_front.sv]
// front of the affine point transform: input register and classification
// depends on apt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module apt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire apt_pkg::in_beat_t item,
    input  wire apt_pkg::q_status_t q_status,
    output logic                   push,
    output apt_pkg::entry_t        push_entry
);

    logic            fr_valid_reg;
    logic            fr_valid_next;
    apt_pkg::entry_t fr_entry_reg;
    apt_pkg::entry_t fr_entry_next;
    logic            accept;
    logic            fr_load;
    logic            keep;

    assign item_stall = fr_valid_reg && q_status.full;
    assign accept     = item_valid && !item_stall;
    assign fr_load    = !fr_valid_reg || !q_status.full;

    // loads that name no row are dropped here
    assign keep = (apt_pkg::cmd_t'(item.command) == apt_pkg::CMD_XFORM)
                  || (item.row_index != apt_pkg::ROW_NONE);

    always_comb
    begin
        fr_entry_next.op   = apt_pkg::cmd_t'(item.command);
        fr_entry_next.addr = {item.row_index, item.column_index};
        if (apt_pkg::cmd_t'(item.command) == apt_pkg::CMD_LOAD)
        begin
            fr_entry_next.a = item.element_value;
            fr_entry_next.b = '0;
            fr_entry_next.c = '0;
        end
        else
        begin
            fr_entry_next.a = item.point_x;
            fr_entry_next.b = item.point_y;
            fr_entry_next.c = item.point_z;
        end
    end

    assign fr_valid_next = fr_load ? (accept && keep) : fr_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fr_load && accept)
        begin
            fr_entry_reg <= fr_entry_next;
        end
    end

    assign push       = fr_valid_reg && !q_status.full;
    assign push_entry = fr_entry_reg;

    `ASSERT_NEXT(fr_xform_kept, clk, rst_n,
        accept && (apt_pkg::cmd_t'(item.command) == apt_pkg::CMD_XFORM), fr_valid_reg)
    `ASSERT_IMPLIES(fr_load_row_ok, clk, rst_n,
        fr_valid_reg && (fr_entry_reg.op == apt_pkg::CMD_LOAD),
        fr_entry_reg.addr[3:2] != apt_pkg::ROW_NONE)

endmodule
`default_nettype wire

[rtl/apt_queue.sv]
// short fifo between front and back of the affine point transform
// depends on apt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module apt_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire apt_pkg::entry_t push_entry,
    input  wire logic            pop,
    output apt_pkg::entry_t      head,
    output apt_pkg::q_status_t   q_status
);

    localparam int unsigned PTR_W = $clog2(apt_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(apt_pkg::QUEUE_DEPTH + 1);

    apt_pkg::entry_t  slot_reg [apt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(apt_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(apt_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head           = slot_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(apt_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    `ASSERT_NEVER(q_no_overflow, clk, rst_n, push && q_status.full)
    `ASSERT_NEVER(q_no_underflow, clk, rst_n, pop && q_status.empty)

endmodule
`default_nettype wire

[rtl/apt_back.sv]
// back of the affine point transform: matrix store, multiply, sum, saturate
// depends on apt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module apt_back #(
    parameter int unsigned FRAC_BITS = apt_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire apt_pkg::q_status_t q_status,
    input  wire apt_pkg::entry_t    head,
    output logic                    pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output apt_pkg::out_beat_t      result
);

    localparam int unsigned SUM_W  = apt_pkg::SUM_W;
    localparam int unsigned PROD_W = apt_pkg::PROD_W;

    logic signed [31:0]       mat_reg  [apt_pkg::ELEMS];
    logic signed [PROD_W-1:0] prod_reg [apt_pkg::ROWS][3];
    logic signed [31:0]       tr_reg   [apt_pkg::ROWS];
    logic signed [SUM_W-1:0]  sum_reg  [apt_pkg::ROWS];
    logic signed [SUM_W-1:0]  shifted  [apt_pkg::ROWS];
    logic signed [31:0]       comp     [apt_pkg::ROWS];
    logic                     clip     [apt_pkg::ROWS];
    logic signed [31:0]       pt       [3];

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic res_valid_reg;
    logic res_valid_next;
    apt_pkg::out_beat_t res_reg;
    apt_pkg::out_beat_t res_next;

    logic out_free;
    logic s2_free;
    logic s1_free;
    logic head_valid;
    logic do_load;
    logic do_xform;

    // ready chain from the output register back to the queue head
    assign out_free   = !res_valid_reg || !result_stall;
    assign s2_free    = !s2_valid_reg || out_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign head_valid = !q_status.empty;
    assign do_load    = head_valid && (head.op == apt_pkg::CMD_LOAD);
    assign do_xform   = head_valid && (head.op == apt_pkg::CMD_XFORM) && s1_free;
    assign pop        = do_load || do_xform;

    assign s1_valid_next  = s1_free ? do_xform : s1_valid_reg;
    assign s2_valid_next  = s2_free ? s1_valid_reg : s2_valid_reg;
    assign res_valid_next = out_free ? s2_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // matrix store, cleared at reset; loads are applied in queue order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < apt_pkg::ELEMS; i++)
            begin
                mat_reg[i] <= '0;
            end
        end
        else if (do_load)
        begin
            for (int i = 0; i < apt_pkg::ELEMS; i++)
            begin
                if (head.addr == 4'(i))
                begin
                    mat_reg[i] <= head.a;
                end
            end
        end
    end

    assign pt[0] = head.a;
    assign pt[1] = head.b;
    assign pt[2] = head.c;

    // stage 1: nine independent products, translation captured alongside
    always_ff @(posedge clk)
    begin
        if (do_xform)
        begin
            for (int r = 0; r < apt_pkg::ROWS; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= PROD_W'(pt[c]) * PROD_W'(mat_reg[r * apt_pkg::COLS + c]);
                end
                tr_reg[r] <= mat_reg[r * apt_pkg::COLS + 3];
            end
        end
    end

    // stage 2: exact row sums
    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            for (int r = 0; r < apt_pkg::ROWS; r++)
            begin
                sum_reg[r] <= SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                              + SUM_W'(prod_reg[r][2])
                              + (SUM_W'(tr_reg[r]) <<< FRAC_BITS);
            end
        end
    end

    // stage 3: arithmetic shift and clip to 32 bits
    always_comb
    begin
        for (int r = 0; r < apt_pkg::ROWS; r++)
        begin
            shifted[r] = sum_reg[r] >>> FRAC_BITS;
            clip[r]    = !((&shifted[r][SUM_W-1:31]) || !(|shifted[r][SUM_W-1:31]));
            if (!clip[r])
            begin
                comp[r] = shifted[r][31:0];
            end
            else if (sum_reg[r][SUM_W-1])
            begin
                comp[r] = apt_pkg::SAT_MIN;
            end
            else
            begin
                comp[r] = apt_pkg::SAT_MAX;
            end
        end
        res_next.out_x     = comp[0];
        res_next.out_y     = comp[1];
        res_next.out_z     = comp[2];
        res_next.saturated = clip[0] || clip[1] || clip[2];
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `ASSERT_IMPLIES(bk_sat_flag, clk, rst_n, result_valid && result.saturated,
        (result.out_x == apt_pkg::SAT_MAX) || (result.out_x == apt_pkg::SAT_MIN)
        || (result.out_y == apt_pkg::SAT_MAX) || (result.out_y == apt_pkg::SAT_MIN)
        || (result.out_z == apt_pkg::SAT_MAX) || (result.out_z == apt_pkg::SAT_MIN))
    `ASSERT_NEXT(bk_s2_to_out, clk, rst_n, s2_valid_reg && out_free, result_valid)

endmodule
`default_nettype wire

[rtl/affine_point_transform_unit.sv]
// top level of the affine point transform unit
// depends on apt_pkg, apt_front, apt_queue and apt_back
//
// usage
//   item channel (item_valid / item_stall / item) carries one beat per item:
//   command 0 loads one matrix element at (row_index, column_index), command 1
//   transforms the point (point_x, point_y, point_z) by the 3x4 matrix.
//   result channel (result_valid / result_stall / result) gives one beat per
//   transform item, in order; load items and loads naming row 3 give none.
//   each result component is the exact sum shifted right by FRAC_BITS and
//   clipped to 32 bits; saturated flags any clipped component.
//   an accepted transform beat passes the front register, queue, product stage,
//   sum stage and output register on its way to result_valid.
//   throughput: one item per cycle while nothing stalls; the nine 32x32 products run in parallel.
//   a load followed directly by a transform is seen by that transform.
//   reset clears the matrix to zero and empties every stage and the queue.
//   when result_stall is high the pipeline fills, then the 4-entry queue,
//   and then item_stall rises; loads at the queue head still drain until a
//   transform reaches the head and waits there.
`default_nettype none
module affine_point_transform_unit #(
    parameter int unsigned FRAC_BITS = apt_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire apt_pkg::in_beat_t  item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output apt_pkg::out_beat_t      result
);

    // front to queue
    logic               push;
    apt_pkg::entry_t    push_entry;
    // queue to back
    logic               pop;
    apt_pkg::entry_t    head;
    apt_pkg::q_status_t q_status;

    // classifies beats and drops loads that name no row
    apt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // keeps loads and transforms in arrival order
    apt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    // owns the matrix, runs the multiply / sum / clip pipeline
    apt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

[tb/sv/affine_point_transform_unit_test.sv]
// self-checking bench for the affine point transform unit: directed table, then random phases
// depends on apt_pkg and affine_point_transform_unit; keeps its own copy of the 3x4 matrix
module affine_point_transform_unit_test;
    import apt_pkg::*;

    localparam int unsigned FRAC        = FRAC_BITS_DEFAULT;
    localparam int unsigned ACC_W       = 72;     // exact sum of three products and translation
    localparam int          QUIET_LIMIT = 4000;   // cycles with no beat on either side
    localparam int          HOLD_CYCLES = 300;    // long output hold for back pressure
    localparam int          SETTLE      = 12;     // wait before the final check for missing results
    localparam int          MAX_REPORTS = 10;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    // one directed row: the beat and, where obvious, the result typed in
    typedef struct {
        in_beat_t  beat;
        bit        pinned;
        out_beat_t want;
    } script_row_t;

    typedef struct {
        bit        pinned;
        out_beat_t want;
    } pin_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_beat_t  item;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_beat_t result;

    // matrix as the block should hold it, row-major, index {row, column}
    logic signed [31:0] matrix [ELEMS];
    out_beat_t          expected_q [$];
    pin_t               pin_q [$];

    int mismatches   = 0;
    int n_loads      = 0;
    int n_skipped    = 0;
    int n_xforms     = 0;
    int n_results    = 0;
    int n_clipped    = 0;

    // idling knobs written by the stimulus process, hold state kept by the receiver, watchdog count
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int hold_asked      = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    affine_point_transform_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        for (int k = 0; k < ELEMS; k++)
            matrix[k] = '0;
    end

    // ------------------------------------------------------------------
    // predictor: exact sum, arithmetic shift (floor), clip to 32 bits
    // ------------------------------------------------------------------
    function automatic out_beat_t transform_point(input logic signed [31:0] px,
                                                  input logic signed [31:0] py,
                                                  input logic signed [31:0] pz);
        out_beat_t               r;
        logic signed [31:0]      coord [3];
        logic signed [31:0]      comp [3];
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] shift_term;
        logic                    clip;
        coord[0] = px;
        coord[1] = py;
        coord[2] = pz;
        clip = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = '0;
            for (int j = 0; j < 3; j++)
                acc = acc + coord[j] * matrix[i * COLS + j];
            // translation enters at the same scale as the products
            shift_term = matrix[i * COLS + 3];
            acc = acc + (shift_term <<< FRAC);
            acc = acc >>> FRAC;
            // fits when every bit above bit 31 repeats the sign
            if (&acc[ACC_W-1:31] || ~|acc[ACC_W-1:31])
                comp[i] = acc[31:0];
            else
            begin
                clip = 1'b1;
                comp[i] = acc[ACC_W-1] ? SAT_MIN : SAT_MAX;
            end
        end
        r.out_x     = comp[0];
        r.out_y     = comp[1];
        r.out_z     = comp[2];
        r.saturated = clip;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly small Q16.16 magnitudes, some full-range words, some extremes
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return SAT_MAX;
                    1:       return SAT_MIN;
                    2:       return 32'sd0;
                    3:       return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
            1, 2:    return $urandom();
            default: return $signed($urandom_range(0, 32'd1 << 20)) - 32'sd524288;
        endcase
    endfunction

    // unused fields carry random junk so the block must ignore them
    function automatic in_beat_t random_beat(cmd_t op, bit allow_missing_row);
        in_beat_t b;
        b.command       = op;
        b.row_index     = allow_missing_row ? 2'($urandom_range(0, 3))
                                            : 2'($urandom_range(0, 2));
        b.column_index  = 2'($urandom_range(0, 3));
        b.element_value = rand_word();
        b.point_x       = rand_word();
        b.point_y       = rand_word();
        b.point_z       = rand_word();
        return b;
    endfunction

    function automatic script_row_t load_row(logic [1:0] r, logic [1:0] c,
                                             logic signed [31:0] v);
        script_row_t s;
        s.beat               = random_beat(CMD_LOAD, 1'b0);
        s.beat.row_index     = r;
        s.beat.column_index  = c;
        s.beat.element_value = v;
        s.pinned             = 1'b0;
        s.want               = '0;
        return s;
    endfunction

    function automatic script_row_t point_row(logic signed [31:0] x,
                                              logic signed [31:0] y,
                                              logic signed [31:0] z,
                                              bit pinned = 1'b0,
                                              logic signed [31:0] wx = '0,
                                              logic signed [31:0] wy = '0,
                                              logic signed [31:0] wz = '0,
                                              logic ws = 1'b0);
        script_row_t s;
        s.beat           = random_beat(CMD_XFORM, 1'b1);
        s.beat.point_x   = x;
        s.beat.point_y   = y;
        s.beat.point_z   = z;
        s.pinned         = pinned;
        s.want.out_x     = wx;
        s.want.out_y     = wy;
        s.want.out_z     = wz;
        s.want.saturated = ws;
        return s;
    endfunction

    // offer one beat, idling first at the current rate; returns once accepted
    task automatic push_item(in_beat_t b, bit pinned = 1'b0, out_beat_t want = '0);
        pin_t p;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        p.pinned = pinned;
        p.want   = want;
        pin_q.push_back(p);
        item       <= b;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // well-formed runs: a few element loads then a burst of points; some noise
    task automatic run_phase(int n_items, int idle_pct, int stall_rate);
        int sent;
        int n_ld;
        int n_pt;
        in_beat_t b;
        sender_idle_pct = idle_pct;
        stall_pct       = stall_rate;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                n_ld = $urandom_range(0, 4);
                n_pt = $urandom_range(1, 8);
                repeat (n_ld)
                    push_item(random_beat(CMD_LOAD, 1'b0));
                repeat (n_pt)
                    push_item(random_beat(CMD_XFORM, 1'b1));
                sent += n_ld + n_pt;
            end
            else
            begin
                b = random_beat(cmd_t'($urandom_range(0, 1)), 1'b1);
                push_item(b);
                // loads to the missing row do nothing, so they are not counted
                if (!(b.command == CMD_LOAD && b.row_index == ROW_NONE))
                    sent++;
            end
        end
    endtask

    task automatic note_error(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result(out_beat_t got);
        out_beat_t want;
        if (expected_q.size() == 0)
        begin
            note_error($sformatf("unexpected result %h %h %h sat %b",
                                 got.out_x, got.out_y, got.out_z, got.saturated));
            return;
        end
        want = expected_q.pop_front();
        if (got.out_x !== want.out_x)
            note_error($sformatf("out_x expected %h got %h", want.out_x, got.out_x));
        if (got.out_y !== want.out_y)
            note_error($sformatf("out_y expected %h got %h", want.out_y, got.out_y));
        if (got.out_z !== want.out_z)
            note_error($sformatf("out_z expected %h got %h", want.out_z, got.out_z));
        if (got.saturated !== want.saturated)
            note_error($sformatf("saturated expected %b got %b",
                                 want.saturated, got.saturated));
    endtask

    // ------------------------------------------------------------------
    // monitor: both sides sampled at the edge, before any update lands
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        in_beat_t  b;
        out_beat_t guess;
        pin_t      p;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                b = item;
                p.pinned = 1'b0;
                if (pin_q.size() != 0)
                    p = pin_q.pop_front();
                if (b.command == CMD_LOAD)
                begin
                    // row three names no row: nothing is written
                    if (b.row_index != ROW_NONE)
                    begin
                        matrix[{b.row_index, b.column_index}] = b.element_value;
                        n_loads++;
                    end
                    else
                        n_skipped++;
                end
                else
                begin
                    guess = transform_point(b.point_x, b.point_y, b.point_z);
                    expected_q.push_back(p.pinned ? p.want : guess);
                    n_xforms++;
                end
            end
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (result.saturated)
                    n_clipped++;
                check_result(result);
            end
        end
    end

    // receiver: random stall, or a long hold when the stimulus asks for one
    always @(posedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // watchdog: too long without a beat on either side means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        script_row_t script [$];
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;

        // after reset the matrix is zero, so any point maps to zero
        script.push_back(point_row(ONE, 2 * ONE, 3 * ONE, 1'b1, 0, 0, 0, 1'b0));
        // loads to the missing row must leave the matrix alone
        script.push_back(load_row(ROW_NONE, 2'd0, 32'sh1234_5678));
        script.push_back(load_row(ROW_NONE, 2'd3, SAT_MIN));
        script.push_back(point_row(SAT_MAX, SAT_MIN, -32'sd1, 1'b1, 0, 0, 0, 1'b0));
        // identity with extreme translations
        script.push_back(load_row(2'd0, 2'd0, ONE));
        script.push_back(load_row(2'd1, 2'd1, ONE));
        script.push_back(load_row(2'd2, 2'd2, ONE));
        script.push_back(load_row(2'd0, 2'd3, SAT_MAX));
        script.push_back(load_row(2'd1, 2'd3, SAT_MIN));
        script.push_back(point_row(0, 0, 0, 1'b1, SAT_MAX, SAT_MIN, 0, 1'b0));
        script.push_back(point_row(ONE, -ONE, 32'sh0000_8000));
        // extremes on top of extreme translations clip both ways
        script.push_back(point_row(SAT_MAX, SAT_MIN, SAT_MIN));
        // half scale on z: the shift floors odd negatives
        script.push_back(load_row(2'd2, 2'd2, 32'sh0000_8000));
        script.push_back(point_row(0, 0, -32'sd1));
        script.push_back(point_row(0, 0, -32'sd3));
        // most negative everywhere: the sum needs more than 64 bits
        script.push_back(load_row(2'd2, 2'd0, SAT_MIN));
        script.push_back(load_row(2'd2, 2'd1, SAT_MIN));
        script.push_back(load_row(2'd2, 2'd2, SAT_MIN));
        script.push_back(load_row(2'd2, 2'd3, SAT_MIN));
        script.push_back(point_row(SAT_MIN, SAT_MIN, SAT_MIN));
        script.push_back(point_row(SAT_MAX, SAT_MAX, SAT_MAX));
        script.push_back(point_row(32'sd1, -32'sd1, 32'sd1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows back to back, so each load is seen by the next point
        sender_idle_pct = 0;
        stall_pct       = 0;
        foreach (script[k])
            push_item(script[k].beat, script[k].pinned, script[k].want);
        drain();

        run_phase(150, 0, 0);
        drain();
        run_phase(150, 62, 0);
        drain();

        // hold the output long enough that the input side has to stall
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_asked++;
        repeat (40)
            push_item(random_beat(CMD_XFORM, 1'b1));
        drain();

        run_phase(150, 0, 62);
        drain();
        run_phase(150, 9, 9);
        drain();

        repeat (SETTLE) @(posedge clk);
        if (expected_q.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_q.size()));

        $display("covered %0d element loads, %0d loads to the missing row, %0d points",
                 n_loads, n_skipped, n_xforms);
        $display("%0d results checked, %0d clipped, under four idle mixes and a long hold",
                 n_results, n_clipped);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/apt_pkg.sv
rtl/apt_front.sv
rtl/apt_queue.sv
rtl/apt_back.sv
rtl/affine_point_transform_unit.sv
tb/sv/affine_point_transform_unit_test.sv
